@@ hdl/c2d_pkg.sv @@
`default_nettype none

package c2d_pkg;

	// geometry
	localparam int MAX_SIZE_DEF = 1024;
	localparam int KERNEL_SIZE  = 3;
	localparam int KTAPS        = KERNEL_SIZE * KERNEL_SIZE;
	localparam int TAP_W        = $clog2(KTAPS);
	localparam int COEFF_BITS   = 7;
	localparam int PIX_W        = 8;
	localparam int PIXEL_MAX    = 255;

	// arithmetic widths: 9 products of an 8-bit pixel and a signed coefficient
	localparam int PROD_W = PIX_W + COEFF_BITS;
	localparam int SUM_W  = PROD_W + 4;
	localparam int MAG_W  = SUM_W - 1;

	// configuration registers
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_SIZE_W = 11;
	localparam int CFG_ROW_W  = KERNEL_SIZE * COEFF_BITS;
	localparam int NORM_W     = 8;
	localparam int CFG_DATA_W = (CFG_ROW_W > CFG_SIZE_W) ? CFG_ROW_W : CFG_SIZE_W;

	localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_SIZE    = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_TOP    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_MIDDLE = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_KERNEL_BOTTOM = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_NORM_DIVISOR  = 3'd4;

	localparam logic [CFG_SIZE_W-1:0] SIZE_RESET = 11'd800;
	localparam logic [NORM_W-1:0]     NORM_RESET = 8'd1;

	// input item op codes
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef struct packed {
		logic             op;
		logic [PIX_W-1:0] pixel_value;
	} in_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] result_value;
		logic             last_of_image;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic             load;
		logic             step;
		logic [TAP_W-1:0] tap;
		logic             prod_en;
		logic             acc_clr;
		logic             acc_add;
		logic             div_start;
		logic             out_load;
	} c2d_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic skip;
		logic emit;
		logic div_done;
		logic out_free;
	} c2d_stat_t;

endpackage

`default_nettype wire

@@ hdl/c2d_div.sv @@
`default_nettype none

module c2d_div import c2d_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [MAG_W-1:0] dividend,
	input  wire logic [NORM_W-1:0] divisor,
	output logic                  done,
	output logic [MAG_W-1:0]      quotient
);

	localparam int CNT_W = $clog2(MAG_W + 1);

	logic [CNT_W-1:0]  cnt_q;
	logic              done_q;
	logic [MAG_W-1:0]  quo_q;
	logic [NORM_W-1:0] rem_q;
	logic [NORM_W:0]   rem_sh;
	logic [NORM_W:0]   rem_sub;
	logic              fits;

	// one restoring step: shift in the next dividend bit, subtract if it fits
	assign rem_sh  = {rem_q, quo_q[MAG_W-1]};
	assign fits    = rem_sh >= {1'b0, divisor};
	assign rem_sub = rem_sh - {1'b0, divisor};

	// step counter, done pulses after the last step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(MAG_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	// quotient shifts in from the bottom as the dividend shifts out the top
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			quo_q <= {quo_q[MAG_W-2:0], fits};
			rem_q <= fits ? rem_sub[NORM_W-1:0] : rem_sh[NORM_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ hdl/c2d_datapath.sv @@
`default_nettype none

module c2d_datapath import c2d_pkg::*; #(
	parameter int MAX_IMAGE_SIZE = MAX_SIZE_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire in_item_t              in_item,
	output out_item_t                  out_item,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	input  wire c2d_cmd_t              cmd,
	output c2d_stat_t                  stat
);

	localparam int COL_W  = $clog2(MAX_IMAGE_SIZE);
	localparam int SIZE_W = $clog2(MAX_IMAGE_SIZE + 1);
	localparam int ROW_W  = $clog2(MAX_IMAGE_SIZE + 2);
	localparam int CNT_W  = $clog2(MAX_IMAGE_SIZE * MAX_IMAGE_SIZE);
	localparam int SQ_W   = 2 * SIZE_W;

	// configuration
	logic [CFG_SIZE_W-1:0] size_cfg_q;
	logic [CFG_ROW_W-1:0]  krow_q [KERNEL_SIZE];
	logic [NORM_W-1:0]     norm_q;
	logic                  size_wr;

	// stream position
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [CNT_W-1:0] emitted_q;
	logic [CNT_W-1:0] sq_m1_q;

	// item and neighborhood
	logic             op_q;
	logic [PIX_W-1:0] pix_q;
	logic [PIX_W-1:0] pix_eff;
	logic [PIX_W-1:0] mid_mem [MAX_IMAGE_SIZE];
	logic [PIX_W-1:0] top_mem [MAX_IMAGE_SIZE];
	logic [PIX_W-1:0] rd_mid_q;
	logic [PIX_W-1:0] rd_top_q;
	logic [PIX_W-1:0] win_q [KTAPS];
	logic [KTAPS-1:0] tap_mask_q;
	logic             last_q;

	// per-item decisions
	logic [SIZE_W-1:0] eff_size;
	logic [ROW_W-1:0]  row_size;
	logic [SQ_W-1:0]   sq;
	logic [SIZE_W-1:0] col_inc;
	logic              wrap;
	logic [ROW_W-1:0]  orow;
	logic [SIZE_W-1:0] ocol;
	logic              top_ok;
	logic              bot_ok;
	logic              left_ok;
	logic              right_ok;
	logic [KERNEL_SIZE-1:0] row_ok;
	logic [KERNEL_SIZE-1:0] col_ok;
	logic [KTAPS-1:0]  tap_mask;

	// multiply-accumulate and result
	logic signed [COEFF_BITS-1:0] coef_all [KTAPS];
	logic signed [PIX_W:0]        pix_s;
	logic signed [PROD_W-1:0]     prod_c;
	logic signed [PROD_W-1:0]     product_s1;
	logic signed [SUM_W-1:0]      prod_ext;
	logic signed [SUM_W-1:0]      acc_q;
	logic                         div_done;
	logic [MAG_W-1:0]             div_quo;
	logic [MAG_W-1:0]             val;
	logic [PIX_W-1:0]             res;
	out_item_t                    out_q;
	logic                         out_valid_q;

	// config registers
	assign size_wr = cfg_we && (cfg_addr == REG_IMAGE_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_cfg_q <= SIZE_RESET;
			krow_q[0]  <= '0;
			krow_q[1]  <= '0;
			krow_q[2]  <= '0;
			norm_q     <= NORM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_IMAGE_SIZE:    size_cfg_q <= cfg_data[CFG_SIZE_W-1:0];
				REG_KERNEL_TOP:    krow_q[0]  <= cfg_data[CFG_ROW_W-1:0];
				REG_KERNEL_MIDDLE: krow_q[1]  <= cfg_data[CFG_ROW_W-1:0];
				REG_KERNEL_BOTTOM: krow_q[2]  <= cfg_data[CFG_ROW_W-1:0];
				REG_NORM_DIVISOR:  norm_q     <= cfg_data[NORM_W-1:0];
				default: ;
			endcase
		end
	end

	// effective size: zero acts as one, oversize clamps to the line store depth
	always_comb begin
		if (size_cfg_q == '0) begin
			eff_size = SIZE_W'(1);
		end else if (32'(size_cfg_q) > 32'(MAX_IMAGE_SIZE)) begin
			eff_size = SIZE_W'(MAX_IMAGE_SIZE);
		end else begin
			eff_size = SIZE_W'(size_cfg_q);
		end
	end

	assign row_size = ROW_W'(eff_size);
	assign sq       = {{SIZE_W{1'b0}}, eff_size} * {{SIZE_W{1'b0}}, eff_size};

	// index of the final output of the image
	always_ff @(posedge clk) begin
		sq_m1_q <= CNT_W'(sq - SQ_W'(1));
	end

	// latch the accepted item
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= in_item.op;
			pix_q <= in_item.pixel_value;
		end
	end

	assign pix_eff = (op_q == OP_DRAIN) ? '0 : pix_q;

	// pixels before the image is complete, drains after; anything else is dropped
	assign stat.skip = (op_q == OP_DRAIN) ? (row_q < row_size) : (row_q >= row_size);

	// line stores: read every cycle at the current column, written on step
	always_ff @(posedge clk) begin
		rd_mid_q <= mid_mem[col_q];
		rd_top_q <= top_mem[col_q];
		if (cmd.step) begin
			mid_mem[col_q] <= pix_eff;
			top_mem[col_q] <= rd_mid_q;
		end
	end

	// position of the output that this arrival completes
	assign col_inc   = SIZE_W'(col_q) + SIZE_W'(1);
	assign wrap      = col_inc >= eff_size;
	assign stat.emit = (row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0));

	always_comb begin
		if (col_q != '0) begin
			orow = row_q - ROW_W'(1);
			ocol = SIZE_W'(col_q) - SIZE_W'(1);
		end else begin
			orow = row_q - ROW_W'(2);
			ocol = eff_size - SIZE_W'(1);
		end
	end

	// zero padding: mask taps that fall outside the image
	assign top_ok   = orow >= ROW_W'(1);
	assign bot_ok   = (orow + ROW_W'(1)) < row_size;
	assign left_ok  = ocol >= SIZE_W'(1);
	assign right_ok = (ocol + SIZE_W'(1)) < eff_size;
	assign row_ok   = {bot_ok, 1'b1, top_ok};
	assign col_ok   = {right_ok, 1'b1, left_ok};

	for (genvar g = 0; g < KTAPS; g++) begin : g_tap
		assign tap_mask[g] = row_ok[g / KERNEL_SIZE] & col_ok[g % KERNEL_SIZE];
		assign coef_all[g] =
			krow_q[g / KERNEL_SIZE][(g % KERNEL_SIZE) * COEFF_BITS +: COEFF_BITS];
	end

	// stream counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			emitted_q <= '0;
		end else if (size_wr) begin
			col_q     <= '0;
			row_q     <= '0;
			emitted_q <= '0;
		end else if (cmd.step) begin
			if (stat.emit && (emitted_q == sq_m1_q)) begin
				col_q     <= '0;
				row_q     <= '0;
				emitted_q <= '0;
			end else begin
				col_q <= wrap ? '0 : COL_W'(col_inc);
				row_q <= wrap ? (row_q + ROW_W'(1)) : row_q;
				if (stat.emit) begin
					emitted_q <= emitted_q + CNT_W'(1);
				end
			end
		end
	end

	// window shift and per-output flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < KTAPS; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.step) begin
			for (int i = 0; i < KERNEL_SIZE; i++) begin
				win_q[i*KERNEL_SIZE]     <= win_q[i*KERNEL_SIZE + 1];
				win_q[i*KERNEL_SIZE + 1] <= win_q[i*KERNEL_SIZE + 2];
			end
			win_q[2] <= rd_top_q;
			win_q[5] <= rd_mid_q;
			win_q[8] <= pix_eff;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			tap_mask_q <= tap_mask;
			last_q     <= (emitted_q == sq_m1_q);
		end
	end

	// shared multiplier, one tap a cycle
	assign pix_s    = $signed({1'b0, win_q[cmd.tap]});
	assign prod_c   = PROD_W'(pix_s) * PROD_W'(coef_all[cmd.tap]);
	assign prod_ext = SUM_W'(product_s1);

	always_ff @(posedge clk) begin
		if (cmd.prod_en) begin
			product_s1 <= tap_mask_q[cmd.tap] ? prod_c : '0;
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + prod_ext;
		end
	end

	// normalization on the magnitude; a negative sum ends at zero anyway
	c2d_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (acc_q[MAG_W-1:0]),
		.divisor  (norm_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign stat.div_done = div_done;

	assign val = (norm_q <= NORM_W'(1)) ? acc_q[MAG_W-1:0] : div_quo;

	always_comb begin
		if (acc_q[SUM_W-1]) begin
			res = '0;
		end else if (val > MAG_W'(PIXEL_MAX)) begin
			res = PIX_W'(PIXEL_MAX);
		end else begin
			res = val[PIX_W-1:0];
		end
	end

	// output register
	assign stat.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.result_value  <= res;
			out_q.last_of_image <= last_q;
		end
	end

	assign out_item  = out_q;
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

@@ hdl/c2d_ctrl.sv @@
`default_nettype none

module c2d_ctrl import c2d_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire c2d_stat_t stat,
	output c2d_cmd_t       cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_READ   = 3'd1;
	localparam logic [2:0] ST_MUL    = 3'd2;
	localparam logic [2:0] ST_SUM    = 3'd3;
	localparam logic [2:0] ST_DSTART = 3'd4;
	localparam logic [2:0] ST_DWAIT  = 3'd5;
	localparam logic [2:0] ST_OUT    = 3'd6;

	localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(KTAPS - 1);

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [TAP_W-1:0] tap_q;
	logic [TAP_W-1:0] tap_d;

	assign in_stall = (state_q != ST_IDLE);

	// next state and commands
	always_comb begin
		state_d       = state_q;
		tap_d         = '0;
		cmd           = '0;
		cmd.tap       = tap_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.step = !stat.skip;
				if (stat.skip || !stat.emit) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.prod_en = 1'b1;
				cmd.acc_clr = (tap_q == '0);
				cmd.acc_add = (tap_q != '0);
				if (tap_q == LAST_TAP) begin
					state_d = ST_SUM;
				end else begin
					tap_d = tap_q + TAP_W'(1);
				end
			end
			ST_SUM: begin
				cmd.acc_add = 1'b1;
				state_d     = ST_DSTART;
			end
			ST_DSTART: begin
				cmd.div_start = 1'b1;
				state_d       = ST_DWAIT;
			end
			ST_DWAIT: begin
				if (stat.div_done) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				cmd.out_load = stat.out_free;
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tap_q   <= '0;
		end else begin
			state_q <= state_d;
			tap_q   <= tap_d;
		end
	end

endmodule

`default_nettype wire

@@ hdl/conv2d_3x3_zero_pad_clamp.sv @@
// 3x3 convolution of a square 8-bit grayscale image streamed in raster order,
// with zero padding to the same size and a clamp to 0..255. Pixels enter on
// in_item with op = pixel; output k leaves after input k + size + 1 has
// arrived, so size + 1 drain items (op = drain) flush the tail, and the final
// output carries last_of_image. A drain before the image is complete, or a
// pixel after it, is dropped. Register writes go through cfg_we/cfg_addr/
// cfg_data while the block is idle; writing image_size restarts the image.
// Items are handled one at a time: an item that yields no output returns
// to idle once it is stored, and an item that yields one also waits for the
// single multiplier that walks the nine taps, the one-bit-per-cycle divider
// (18 steps) that normalizes the sum, and any wait on out_stall.
`default_nettype none

module conv2d_3x3_zero_pad_clamp import c2d_pkg::*; #(
	parameter int MAX_IMAGE_SIZE = MAX_SIZE_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_item_t              in_item,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_item
);

	c2d_cmd_t  cmd;
	c2d_stat_t stat;

	// sequencer
	c2d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// line stores, window, multiply-accumulate, divider, output register
	c2d_datapath #(
		.MAX_IMAGE_SIZE (MAX_IMAGE_SIZE)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.in_item   (in_item),
		.out_item  (out_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

`default_nettype wire

@@ dv/conv2d_3x3_zero_pad_clamp_tb.sv @@
module conv2d_3x3_zero_pad_clamp_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import c2d_pkg::*;

	localparam int LINE_LEN      = MAX_SIZE_DEF;
	localparam int QUIET_LIMIT   = 5000;
	localparam int SETTLE_CYCLES = 40;
	localparam int RANDOM_ITEMS  = 400;

	// kernel row patterns: all +63, all -64, center tap only at +63
	localparam logic [CFG_ROW_W-1:0] ROW_ALL_POS    = {3{7'h3F}};
	localparam logic [CFG_ROW_W-1:0] ROW_ALL_NEG    = {3{7'h40}};
	localparam logic [CFG_ROW_W-1:0] ROW_CENTER_POS = {7'h00, 7'h3F, 7'h00};

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	// one slot of the pending stream: an item, or a hold-off marker
	typedef struct {
		bit       hold;
		in_item_t item;
	} stream_slot_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  cfg_we   = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_item  = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_item;

	int unsigned send_gap_pct   = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned err_cnt        = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned stim_count     = 0;

	stream_slot_t pixel_stream[$];
	out_item_t    expected_pixels[$];

	// shadow registers and image state
	logic [CFG_SIZE_W-1:0] sh_size = SIZE_RESET;
	logic [CFG_ROW_W-1:0]  sh_kernel [KERNEL_SIZE] = '{default: '0};
	logic [NORM_W-1:0]     sh_div = NORM_RESET;
	bit [PIX_W-1:0]        line_mem [2*LINE_LEN];
	bit [PIX_W-1:0]        win [KERNEL_SIZE][KERNEL_SIZE];
	int unsigned           in_col  = 0;
	int unsigned           in_row  = 0;
	int unsigned           emitted = 0;

	conv2d_3x3_zero_pad_clamp u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// advance the image by one accepted item; queue the output pixel it yields
	function automatic void conv_step(in_item_t it);
		int unsigned side, r, c, orow, ocol;
		bit [PIX_W-1:0] p, top, mid;
		logic signed [COEFF_BITS-1:0] k;
		int acc;
		out_item_t res;
		side = (sh_size == 0) ? 1 : (sh_size > LINE_LEN) ? LINE_LEN : int'(sh_size);
		r = in_row;
		c = (in_col >= side) ? side - 1 : in_col;
		// pixel after the image is complete, or drain before it is: dropped
		if (it.op == OP_PIXEL && r >= side)
			return;
		if (it.op == OP_DRAIN && r < side)
			return;
		p = (it.op == OP_DRAIN) ? '0 : it.pixel_value;

		// shift the window, feed the new column from the line stores
		top = line_mem[LINE_LEN + c];
		mid = line_mem[c];
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			win[i][0] = win[i][1];
			win[i][1] = win[i][2];
		end
		win[0][2] = top;
		win[1][2] = mid;
		win[2][2] = p;
		line_mem[LINE_LEN + c] = mid;
		line_mem[c] = p;

		c++;
		if (c >= side) begin
			c = 0;
			in_row = r + 1;
		end
		in_col = c;
		c = (c == 0) ? side - 1 : c - 1;

		// first output appears once row 1 column 1 is in
		if (!(r >= 2 || (r == 1 && c >= 1)))
			return;
		if (c >= 1) begin
			orow = r - 1;
			ocol = c - 1;
		end else begin
			orow = r - 2;
			ocol = side - 1;
		end

		// taps outside the image count as zero
		acc = 0;
		for (int i = 0; i < KERNEL_SIZE; i++) begin
			for (int j = 0; j < KERNEL_SIZE; j++) begin
				if ((i == 0 && orow < 1) || (i == 2 && orow + 1 >= side) ||
				    (j == 0 && ocol < 1) || (j == 2 && ocol + 1 >= side))
					continue;
				k = sh_kernel[i][j*COEFF_BITS +: COEFF_BITS];
				acc += int'(win[i][j]) * int'(k);
			end
		end
		if (sh_div > 1)
			acc = acc / int'(sh_div);
		if (acc < 0)
			acc = 0;
		if (acc > PIXEL_MAX)
			acc = PIXEL_MAX;

		res.result_value  = acc[PIX_W-1:0];
		res.last_of_image = (emitted == side * side - 1);
		if (res.last_of_image) begin
			in_col  = 0;
			in_row  = 0;
			emitted = 0;
		end else begin
			emitted = (emitted + 1) & 32'hFFFFF;
		end
		expected_pixels.push_back(res);
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
	                               input int unsigned want);
		if (err_cnt < 50)
			$display("%0t mismatch: %s got %0d want %0d", $time, what, got, want);
		err_cnt++;
	endtask

	// driver: present the next pending item once the current one is taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				conv_step(in_item);
			if (!in_valid || !in_stall) begin
				if (pixel_stream.size() != 0 && pixel_stream[0].hold) begin
					// hold off until every pending result is out
					if (expected_pixels.size() == 0)
						void'(pixel_stream.pop_front());
					in_valid <= 1'b0;
				end else if (pixel_stream.size() != 0 &&
				             $urandom_range(99) >= send_gap_pct) begin
					in_item <= pixel_stream[0].item;
					void'(pixel_stream.pop_front());
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each output pixel with the oldest expected one
	always @(posedge clk) begin : check_results
		out_item_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_pixels.size() == 0) begin
					report_mismatch("unexpected output pixel", out_item.result_value, 0);
				end else begin
					want = expected_pixels.pop_front();
					if (out_item.result_value !== want.result_value)
						report_mismatch("result_value", out_item.result_value,
						                want.result_value);
					if (out_item.last_of_image !== want.last_of_image)
						report_mismatch("last_of_image", out_item.last_of_image,
						                want.last_of_image);
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// watchdog on cycles with no traffic at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t watchdog: no traffic for %0d cycles", $time, quiet_cycles);
				$display("conv2d_3x3_zero_pad_clamp regression: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic set_idling(input idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
			IDLE_SEND: begin send_gap_pct = 54; recv_stall_pct = 0;  end
			IDLE_RECV: begin send_gap_pct = 0;  recv_stall_pct = 54; end
			default:   begin send_gap_pct = 23; recv_stall_pct = 23; end
		endcase
	endtask

	task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= val;
		case (idx)
			REG_IMAGE_SIZE: begin
				sh_size = val[CFG_SIZE_W-1:0];
				in_col  = 0;
				in_row  = 0;
				emitted = 0;
			end
			REG_KERNEL_TOP:    sh_kernel[0] = val[CFG_ROW_W-1:0];
			REG_KERNEL_MIDDLE: sh_kernel[1] = val[CFG_ROW_W-1:0];
			REG_KERNEL_BOTTOM: sh_kernel[2] = val[CFG_ROW_W-1:0];
			REG_NORM_DIVISOR:  sh_div = val[NORM_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_config(input logic [CFG_DATA_W-1:0] size_val,
	                           input logic [CFG_DATA_W-1:0] top,
	                           input logic [CFG_DATA_W-1:0] mid,
	                           input logic [CFG_DATA_W-1:0] bot,
	                           input logic [CFG_DATA_W-1:0] div_val);
		write_reg(REG_IMAGE_SIZE, size_val);
		write_reg(REG_KERNEL_TOP, top);
		write_reg(REG_KERNEL_MIDDLE, mid);
		write_reg(REG_KERNEL_BOTTOM, bot);
		write_reg(REG_NORM_DIVISOR, div_val);
	endtask

	// block is idle: nothing pending, nothing in flight, then let it settle
	task automatic wait_drained();
		while (pixel_stream.size() != 0 || in_valid || expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_item(input logic kind, input logic [PIX_W-1:0] pix);
		stream_slot_t s;
		s.hold = 1'b0;
		s.item.op = kind;
		s.item.pixel_value = pix;
		pixel_stream.push_back(s);
		stim_count++;
	endtask

	task automatic push_hold();
		stream_slot_t s;
		s.hold = 1'b1;
		s.item = '0;
		pixel_stream.push_back(s);
	endtask

	function automatic logic [CFG_DATA_W-1:0] pick_row();
		case ($urandom_range(9))
			0: return '0;
			1: return {CFG_DATA_W{1'b1}};
			2: return CFG_DATA_W'(ROW_ALL_POS);
			3: return CFG_DATA_W'(ROW_ALL_NEG);
			4: return CFG_DATA_W'(ROW_CENTER_POS);
			default: return CFG_DATA_W'($urandom);
		endcase
	endfunction

	// divisor in the low bits; upper data bits are don't-care
	function automatic logic [CFG_DATA_W-1:0] pick_div();
		logic [CFG_DATA_W-1:0] v;
		v = CFG_DATA_W'($urandom);
		case ($urandom_range(5))
			0: v[NORM_W-1:0] = '0;
			1: v[NORM_W-1:0] = 8'd1;
			2: v[NORM_W-1:0] = 8'd255;
			3: v[NORM_W-1:0] = NORM_W'($urandom_range(2, 12));
			default: v[NORM_W-1:0] = NORM_W'($urandom_range(1, 255));
		endcase
		return v;
	endfunction

	// one image: pixels then size + 1 drains, with stray items mixed in;
	// a cut image stops early and is restarted by the next size write
	task automatic queue_image(input int unsigned side, input bit cut);
		int unsigned npix, total, stop_at;
		logic [PIX_W-1:0] pix;
		npix    = side * side;
		total   = npix + side + 1;
		stop_at = cut ? $urandom_range(total - 1) : total;
		for (int unsigned k = 0; k < stop_at; k++) begin
			if ($urandom_range(99) < 4)
				push_item((k < npix) ? OP_DRAIN : OP_PIXEL, PIX_W'($urandom));
			if ($urandom_range(99) < 2)
				push_hold();
			case ($urandom_range(7))
				0: pix = '0;
				1: pix = '1;
				default: pix = PIX_W'($urandom);
			endcase
			push_item((k < npix) ? OP_PIXEL : OP_DRAIN, pix);
		end
	endtask

	initial begin : stimulus
		int unsigned side, img;
		logic [CFG_DATA_W-1:0] size_val;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// 3x3 image on reset kernel and divisor: every output is zero
		set_idling(IDLE_NONE);
		write_reg(REG_IMAGE_SIZE, CFG_DATA_W'(3));
		push_item(OP_DRAIN, 8'hA5);
		push_item(OP_PIXEL, 8'h00);
		push_item(OP_PIXEL, 8'hFF);
		push_item(OP_PIXEL, 8'h01);
		push_item(OP_PIXEL, 8'h80);
		push_hold();
		push_item(OP_PIXEL, 8'h7F);
		push_item(OP_PIXEL, 8'hFF);
		push_item(OP_PIXEL, 8'h00);
		push_item(OP_PIXEL, 8'hFE);
		push_item(OP_PIXEL, 8'h55);
		push_item(OP_DRAIN, 8'h00);
		push_item(OP_PIXEL, 8'hFF);
		push_item(OP_DRAIN, 8'hFF);
		push_item(OP_DRAIN, 8'h5A);
		push_item(OP_DRAIN, 8'h00);
		wait_drained();

		// size zero acts as 1x1, divisor zero as no division; clamps high
		set_idling(IDLE_BOTH);
		load_config('0, CFG_DATA_W'(ROW_ALL_NEG), CFG_DATA_W'(ROW_CENTER_POS),
		            {CFG_DATA_W{1'b1}}, '0);
		push_item(OP_PIXEL, 8'hFF);
		push_item(OP_DRAIN, 8'h00);
		push_item(OP_DRAIN, 8'hFF);
		wait_drained();

		// 2x2 image, largest divisor
		set_idling(IDLE_RECV);
		load_config(CFG_DATA_W'(2), CFG_DATA_W'(ROW_ALL_POS), CFG_DATA_W'(ROW_ALL_NEG),
		            CFG_DATA_W'(ROW_CENTER_POS), CFG_DATA_W'(255));
		push_item(OP_PIXEL, 8'hFF);
		push_item(OP_PIXEL, 8'h00);
		push_item(OP_PIXEL, 8'hFF);
		push_item(OP_PIXEL, 8'h80);
		push_item(OP_DRAIN, 8'h00);
		push_item(OP_DRAIN, 8'h00);
		push_item(OP_DRAIN, 8'h00);
		wait_drained();

		// oversized size register acts as the maximum: the image stays far from
		// complete, so nothing comes out and a drain is dropped; the next size
		// write restarts the image
		set_idling(IDLE_NONE);
		load_config({CFG_DATA_W{1'b1}}, pick_row(), pick_row(), pick_row(),
		            CFG_DATA_W'(1));
		for (int k = 0; k < 24; k++)
			push_item(OP_PIXEL, PIX_W'($urandom));
		push_item(OP_DRAIN, 8'h00);
		wait_drained();

		// random images, mostly small, a few larger, some cut short
		img = 0;
		while (stim_count < RANDOM_ITEMS) begin
			side = ($urandom_range(9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
			size_val = CFG_DATA_W'($urandom);
			size_val[CFG_SIZE_W-1:0] = (side == 1 && $urandom_range(1) == 0) ?
			                           '0 : CFG_SIZE_W'(side);
			set_idling(idle_mode_t'(img % 4));
			load_config(size_val, pick_row(), pick_row(), pick_row(), pick_div());
			queue_image(side, $urandom_range(11) == 0);
			wait_drained();
			img++;
		end

		if (err_cnt == 0)
			$display("conv2d_3x3_zero_pad_clamp regression: pass");
		else
			$display("conv2d_3x3_zero_pad_clamp regression: fail");
		$finish;
	end

endmodule
